// ===== rtl/qrm_pkg.sv =====
// Shared widths and the product bundle for the quaternion-to-matrix pipeline.
`default_nettype none
package qrm_pkg;

  localparam int CW      = 17;     // reduced component, range +/-2^15
  localparam int PW      = 34;     // signed products and element polynomials
  localparam int NW      = 33;     // squared length and element magnitudes
  localparam int RW      = 34;     // divider partial remainder
  localparam int NEL     = 9;      // matrix elements
  localparam int RED_LIM = 32768;  // component limit after reduction

  typedef struct packed {
    logic [NW-1:0]           n;
    logic [NEL-1:0][NW-1:0]  mag;
    logic [NEL-1:0]          neg;
    logic                    zero;
  } qrm_prod_t;

endpackage
`default_nettype wire

// ===== rtl/qrm_in_if.sv =====
// Input channel: one quaternion per item.
`default_nettype none
interface qrm_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_w;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/qrm_out_if.sv =====
// Result channel: nine matrix elements and the zero-length flag.
`default_nettype none
interface qrm_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic                zero_length;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  zero_length, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  zero_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/qrm_front.sv =====
// Front end: range reduction, products, squared length and element polynomials.
`default_nettype none
module qrm_front #(
  parameter int IN_WIDTH = 16
) (
  input  logic                       clk,
  input  logic [2:0]                 en,
  input  logic signed [IN_WIDTH-1:0] quat_w,
  input  logic signed [IN_WIDTH-1:0] quat_x,
  input  logic signed [IN_WIDTH-1:0] quat_y,
  input  logic signed [IN_WIDTH-1:0] quat_z,
  output qrm_pkg::qrm_prod_t         prod_o
);
  import qrm_pkg::*;

  localparam int EXT_W  = (IN_WIDTH > CW) ? IN_WIDTH : CW;
  localparam int SH_MAX = (IN_WIDTH > CW - 1) ? IN_WIDTH - (CW - 1) : 0;
  localparam int SHW    = (SH_MAX > 0) ? $clog2(SH_MAX + 1) : 1;
  localparam logic signed [EXT_W-1:0] LO = EXT_W'(-RED_LIM);
  localparam logic signed [EXT_W-1:0] HI = EXT_W'(RED_LIM);

  // stage 1: common right shift so every component fits +/-2^15
  logic signed [EXT_W-1:0] ext [4];
  logic signed [CW-1:0]    red_nxt [4];
  logic signed [CW-1:0]    red_r [4];
  logic [SHW-1:0]          sel;

  always_comb begin
    logic                    ok;
    logic signed [EXT_W-1:0] sh;
    ext[0] = EXT_W'(quat_w);
    ext[1] = EXT_W'(quat_x);
    ext[2] = EXT_W'(quat_y);
    ext[3] = EXT_W'(quat_z);
    sel = SHW'(SH_MAX);
    for (int s = SH_MAX; s >= 0; s--) begin
      ok = 1'b1;
      for (int k = 0; k < 4; k++) begin
        sh = ext[k] >>> s;
        if (sh < LO || sh > HI) ok = 1'b0;
      end
      if (ok) sel = SHW'(s);
    end
    for (int k = 0; k < 4; k++) begin
      sh = ext[k] >>> sel;
      red_nxt[k] = sh[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 4; k++) red_r[k] <= red_nxt[k];
    end
  end

  // stage 2: four squares and six cross products
  logic signed [PW-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ww_r <= PW'(red_r[0] * red_r[0]);
      xx_r <= PW'(red_r[1] * red_r[1]);
      yy_r <= PW'(red_r[2] * red_r[2]);
      zz_r <= PW'(red_r[3] * red_r[3]);
      xy_r <= PW'(red_r[1] * red_r[2]);
      xz_r <= PW'(red_r[1] * red_r[3]);
      yz_r <= PW'(red_r[2] * red_r[3]);
      wx_r <= PW'(red_r[0] * red_r[1]);
      wy_r <= PW'(red_r[0] * red_r[2]);
      wz_r <= PW'(red_r[0] * red_r[3]);
    end
  end

  // stage 3: length and sign/magnitude of each element polynomial
  logic signed [PW-1:0] p [NEL];
  logic signed [PW-1:0] nsum;
  qrm_prod_t            prod_nxt, prod_r;

  always_comb begin
    logic signed [PW-1:0] a;
    nsum = ww_r + xx_r + yy_r + zz_r;
    p[0] = ww_r + xx_r - yy_r - zz_r;
    p[1] = (xy_r - wz_r) <<< 1;
    p[2] = (xz_r + wy_r) <<< 1;
    p[3] = (xy_r + wz_r) <<< 1;
    p[4] = ww_r - xx_r + yy_r - zz_r;
    p[5] = (yz_r - wx_r) <<< 1;
    p[6] = (xz_r - wy_r) <<< 1;
    p[7] = (yz_r + wx_r) <<< 1;
    p[8] = ww_r - xx_r - yy_r + zz_r;
    prod_nxt.n    = nsum[NW-1:0];
    prod_nxt.zero = (nsum == '0);
    for (int e = 0; e < NEL; e++) begin
      prod_nxt.neg[e] = p[e][PW-1];
      a = p[e][PW-1] ? -p[e] : p[e];
      prod_nxt.mag[e] = a[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) prod_r <= prod_nxt;
  end

  assign prod_o = prod_r;

endmodule
`default_nettype wire

// ===== rtl/qrm_div.sv =====
// Pipelined restoring divider: one quotient bit of mag*2^(OW-1)/n per stage.
`default_nettype none
module qrm_div #(
  parameter int OUT_WIDTH = 16
) (
  input  logic                     clk,
  input  logic [OUT_WIDTH-1:0]     en,
  input  logic [qrm_pkg::NW-1:0]   mag_i,
  input  logic [qrm_pkg::NW-1:0]   n_i,
  input  logic                     neg_i,
  output logic [OUT_WIDTH-1:0]     quo_o,
  output logic                     neg_o
);
  import qrm_pkg::*;

  localparam int STEPS = OUT_WIDTH;

  logic [RW-1:0]        rem_r [STEPS-1];
  logic [OUT_WIDTH-1:0] quo_r [STEPS];
  logic [NW-1:0]        n_r   [STEPS];
  logic                 neg_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_st
    logic [RW-1:0]        t, nn;
    logic [OUT_WIDTH-1:0] qp;
    logic                 ng, ge;

    if (k == 0) begin : g_first
      assign t  = {1'b0, mag_i};
      assign nn = {1'b0, n_i};
      assign qp = '0;
      assign ng = neg_i;
    end else begin : g_next
      // remainder stays below n, so the doubled value still fits
      assign t  = {rem_r[k-1][RW-2:0], 1'b0};
      assign nn = {1'b0, n_r[k-1]};
      assign qp = quo_r[k-1];
      assign ng = neg_r[k-1];
    end

    assign ge = (t >= nn);

    always_ff @(posedge clk) begin
      if (en[k]) begin
        quo_r[k] <= {qp[OUT_WIDTH-2:0], ge};
        n_r[k]   <= nn[NW-1:0];
        neg_r[k] <= ng;
      end
    end

    if (k < STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[k]) rem_r[k] <= ge ? t - nn : t;
      end
    end
  end

  assign quo_o = quo_r[STEPS-1];
  assign neg_o = neg_r[STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/quaternion_to_rotation_matrix.sv =====
// Throughput: one item per cycle while the output is not stalled; three front
// stages, one divider stage per quotient bit (nine dividers in lockstep) and a
// rounding/output register. Empty stages fill while the output waits, so bubbles
// are squeezed out. Reset (synchronous, rst_n low) clears all stage valid bits;
// data needs none.
`default_nettype none
module quaternion_to_rotation_matrix #(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  qrm_in_if.sink     in_q,
  qrm_out_if.source  out_m
);
  import qrm_pkg::*;

  localparam int F   = OUT_WIDTH - 2;
  localparam int D0  = 3;
  localparam int NST = OUT_WIDTH + 4;
  localparam logic [OUT_WIDTH-1:0] FULL = OUT_WIDTH'(1) << F;

  logic [NST-1:0] v_r, v_nxt, adv;

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || out_m.ready;
    for (int i = NST - 2; i >= 0; i--) adv[i] = !v_r[i] || adv[i+1];
    if (adv[0]) v_nxt[0] = in_q.valid;
    else        v_nxt[0] = v_r[0];
    for (int i = 1; i < NST; i++) begin
      if (adv[i]) v_nxt[i] = v_r[i-1];
      else        v_nxt[i] = v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  assign in_q.ready = adv[0];

  qrm_prod_t prod;

  qrm_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk    (clk),
    .en     (adv[2:0]),
    .quat_w (in_q.quat_w),
    .quat_x (in_q.quat_x),
    .quat_y (in_q.quat_y),
    .quat_z (in_q.quat_z),
    .prod_o (prod)
  );

  logic [OUT_WIDTH-1:0] quo [NEL];
  logic                 qneg [NEL];

  for (genvar e = 0; e < NEL; e++) begin : g_div
    qrm_div #(.OUT_WIDTH(OUT_WIDTH)) u_div (
      .clk   (clk),
      .en    (adv[D0 +: OUT_WIDTH]),
      .mag_i (prod.mag[e]),
      .n_i   (prod.n),
      .neg_i (prod.neg[e]),
      .quo_o (quo[e]),
      .neg_o (qneg[e])
    );
  end

  // zero-length flag rides alongside the divider stages
  logic z_r [OUT_WIDTH];
  always_ff @(posedge clk) begin
    if (adv[D0]) z_r[0] <= prod.zero;
    for (int k = 1; k < OUT_WIDTH; k++) begin
      if (adv[D0+k]) z_r[k] <= z_r[k-1];
    end
  end

  // output stage: round half away from zero, clamp, apply sign
  logic signed [OUT_WIDTH-1:0] m_nxt [NEL];
  logic signed [OUT_WIDTH-1:0] m_r [NEL];
  logic                        zl_r;

  always_comb begin
    logic [OUT_WIDTH:0]   q1;
    logic [OUT_WIDTH-1:0] q;
    for (int e = 0; e < NEL; e++) begin
      q1 = {1'b0, quo[e]} + (OUT_WIDTH+1)'(1);
      q  = q1[OUT_WIDTH:1];
      if (q > FULL) q = FULL;
      if (z_r[OUT_WIDTH-1]) m_nxt[e] = '0;
      else                  m_nxt[e] = qneg[e] ? -q : q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      for (int e = 0; e < NEL; e++) m_r[e] <= m_nxt[e];
      zl_r <= z_r[OUT_WIDTH-1];
    end
  end

  assign out_m.valid       = v_r[NST-1];
  assign out_m.m00         = m_r[0];
  assign out_m.m01         = m_r[1];
  assign out_m.m02         = m_r[2];
  assign out_m.m10         = m_r[3];
  assign out_m.m11         = m_r[4];
  assign out_m.m12         = m_r[5];
  assign out_m.m20         = m_r[6];
  assign out_m.m21         = m_r[7];
  assign out_m.m22         = m_r[8];
  assign out_m.zero_length = zl_r;

  a_zero_elems: assert property (@(posedge clk) disable iff (!rst_n)
    (out_m.valid && out_m.zero_length) |->
      (out_m.m00 == '0 && out_m.m11 == '0 && out_m.m22 == '0 && out_m.m01 == '0))
    else $error("zero-length item with nonzero elements");

  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid |-> ($signed(out_m.m00) <= $signed(FULL) &&
                     $signed(out_m.m00) >= -$signed(FULL)))
    else $error("element outside +/-1.0");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r && !out_m.ready) |-> !in_q.ready)
    else $error("item accepted into a full stalled pipeline");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NST-1] && !out_m.ready) |=> (v_r[NST-1] && $stable(m_r[0])))
    else $error("waiting result lost or changed");

endmodule
`default_nettype wire

// ===== test/quaternion_to_rotation_matrix_test.sv =====
// Testbench for the quaternion-to-rotation-matrix pipeline: directed table, random stream.
`default_nettype none
module quaternion_to_rotation_matrix_test;

  localparam int W = 16;
  localparam int FRAC = W - 2;
  localparam int N_RANDOM = 1830;

  typedef struct {
    logic signed [W-1:0] m [9];
    logic                zero_length;
  } matrix_t;

  typedef struct {
    logic signed [W-1:0] q [4];
    bit                  has_fixed;
    matrix_t             fixed;
  } quat_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qrm_in_if  #(.W(W)) in_q ();
  qrm_out_if #(.W(W)) out_m ();

  quaternion_to_rotation_matrix #(.IN_WIDTH(W), .OUT_WIDTH(W)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_q(in_q.sink), .out_m(out_m.source)
  );

  always #5 clk = ~clk;

  matrix_t   pending_matrices[$];
  quat_row_t rows[$];
  int        mismatches = 0;
  int        matrices_seen = 0;
  int        zero_seen = 0;
  bit        calm = 1'b0;
  bit        stim_done = 1'b0;

  // Element of the normalized matrix: p/n rounded to nearest, ties away, saturated.
  function automatic logic signed [W-1:0] scaled_ratio(longint p, longint n);
    longint mag;
    longint q;
    mag = (p < 0) ? -p : p;
    q = ((mag <<< (FRAC + 1)) + n) / (2 * n);
    if (q > (longint'(1) <<< FRAC)) q = longint'(1) <<< FRAC;
    if (p < 0) q = -q;
    return q[W-1:0];
  endfunction

  function automatic matrix_t rotation_of(logic signed [W-1:0] q [4]);
    matrix_t r;
    longint w, x, y, z, n;
    longint p [9];
    w = q[0]; x = q[1]; y = q[2]; z = q[3];
    n = w*w + x*x + y*y + z*z;
    r.zero_length = (n == 0);
    if (n == 0) begin
      for (int i = 0; i < 9; i++) r.m[i] = '0;
      return r;
    end
    p[0] = w*w + x*x - y*y - z*z;
    p[1] = 2 * (x*y - w*z);
    p[2] = 2 * (x*z + w*y);
    p[3] = 2 * (x*y + w*z);
    p[4] = w*w - x*x + y*y - z*z;
    p[5] = 2 * (y*z - w*x);
    p[6] = 2 * (x*z - w*y);
    p[7] = 2 * (y*z + w*x);
    p[8] = w*w - x*x - y*y + z*z;
    for (int i = 0; i < 9; i++) r.m[i] = scaled_ratio(p[i], n);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
             matrices_seen);
    mismatches++;
  endtask

  function automatic void add_row(int w, int x, int y, int z, bit fixed_on,
                                  int d = 0, int o = 0, int zl = 0);
    quat_row_t r;
    r.q[0] = W'(w); r.q[1] = W'(x); r.q[2] = W'(y); r.q[3] = W'(z);
    r.has_fixed = fixed_on;
    for (int i = 0; i < 9; i++) r.fixed.m[i] = ((i % 4) == 0) ? W'(d) : W'(o);
    r.fixed.zero_length = zl[0];
    rows.push_back(r);
  endfunction

  task automatic send_quat(logic signed [W-1:0] q [4], bit has_fixed, matrix_t fixed);
    matrix_t model;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_q.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_q.valid  <= 1'b1;
    in_q.quat_w <= q[0];
    in_q.quat_x <= q[1];
    in_q.quat_y <= q[2];
    in_q.quat_z <= q[3];
    model = rotation_of(q);
    if (has_fixed) begin
      for (int i = 0; i < 9; i++)
        if (model.m[i] !== fixed.m[i]) report_mismatch("table vs predictor", model.m[i],
                                                       fixed.m[i]);
    end
    pending_matrices.push_back(has_fixed ? fixed : model);
    do @(posedge clk); while (!in_q.ready);
  endtask

  // Sink side with random back-pressure bursts.
  initial begin
    int hold;
    hold = 0;
    out_m.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold > 0) begin
        out_m.ready <= 1'b0;
        hold--;
      end else begin
        out_m.ready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) hold = $urandom_range(1, 3);
      end
      @(posedge clk);
      if (out_m.valid && out_m.ready) begin
        matrix_t want;
        logic signed [W-1:0] got [9];
        got = '{out_m.m00, out_m.m01, out_m.m02, out_m.m10, out_m.m11, out_m.m12,
                out_m.m20, out_m.m21, out_m.m22};
        if (pending_matrices.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = pending_matrices.pop_front();
          for (int i = 0; i < 9; i++)
            if (got[i] !== want.m[i])
              report_mismatch($sformatf("m%0d%0d", i / 3, i % 3), got[i], want.m[i]);
          if (out_m.zero_length !== want.zero_length)
            report_mismatch("zero_length", out_m.zero_length, want.zero_length);
          if (out_m.zero_length === 1'b1) zero_seen++;
        end
        matrices_seen++;
      end
    end
  end

  initial begin
    logic signed [W-1:0] q [4];
    matrix_t none;
    int pick;
    int mx;
    in_q.valid = 1'b0;
    in_q.quat_w = '0; in_q.quat_x = '0; in_q.quat_y = '0; in_q.quat_z = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero quaternion, pure axes (identity and half turns), extremes and mixed values.
    add_row(0, 0, 0, 0, 1, 0, 0, 1);
    add_row(4096, 0, 0, 0, 1, 16384, 0);
    add_row(-32768, 0, 0, 0, 1, 16384, 0);
    add_row(32767, 0, 0, 0, 1, 16384, 0);
    add_row(1, 0, 0, 0, 1, 16384, 0);
    add_row(0, -1, 0, 0, 0);
    add_row(0, 32767, 0, 0, 0);
    add_row(0, 0, -32768, 0, 0);
    add_row(0, 0, 0, 1, 0);
    add_row(-32768, -32768, -32768, -32768, 0);
    add_row(32767, 32767, 32767, 32767, 0);
    add_row(32767, -32768, 32767, -32768, 0);
    add_row(-1, -1, -1, -1, 0);
    add_row(1, 1, 0, 0, 0);
    add_row(1, 2, 3, 4, 0);
    add_row(-32768, 1, 0, 0, 0);
    add_row(3, 1, 1, 1, 0);
    add_row(21845, -21846, 10922, -5461, 0);
    add_row(0, 0, 0, 0, 1, 0, 0, 1);

    foreach (rows[i]) send_quat(rows[i].q, rows[i].has_fixed, rows[i].fixed);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k > N_RANDOM - 200) calm = 1'b1;
      pick = $urandom_range(0, 9);
      // Mix of full-range, small-magnitude, sparse and zero quaternions.
      mx = (pick < 5) ? 65535 : (pick < 8) ? 255 : 3;
      for (int j = 0; j < 4; j++) begin
        if (mx == 65535) q[j] = W'($urandom);
        else q[j] = W'($signed($urandom_range(0, 2 * mx)) - mx);
        if (pick == 9 && $urandom_range(0, 1)) q[j] = '0;
      end
      send_quat(q, 1'b0, none);
    end
    in_q.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (2 * W + 10) @(posedge clk);
    $display("Covered %0d quaternions incl. zero, axis and full-scale cases; %0d zero-length",
             rows.size() + N_RANDOM, zero_seen);
    $display("Checked %0d matrices under random stalls on both channels", matrices_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d results outstanding", pending_matrices.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== quaternion_to_rotation_matrix.f =====
rtl/qrm_pkg.sv
rtl/qrm_in_if.sv
rtl/qrm_out_if.sv
rtl/qrm_front.sv
rtl/qrm_div.sv
rtl/quaternion_to_rotation_matrix.sv
test/quaternion_to_rotation_matrix_test.sv
